FILE: src/tbed_pkg.sv
// ----------------------------------------------------------------------------
// tbed_pkg
// shared types and constants of the two-button event detector
// ----------------------------------------------------------------------------
`default_nettype none

package tbed_pkg;

    // event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_BOTH_LONG    = 3'd1;
    localparam logic [2:0] EV_ID_LONG_END  = 3'd2;
    localparam logic [2:0] EV_ID_SHORT     = 3'd3;
    localparam logic [2:0] EV_EXEC_PRESS   = 3'd4;
    localparam logic [2:0] EV_EXEC_RELEASE = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK       = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [9:0]  TICK_RST       = 10'd10;

    typedef struct packed {
        logic id_pressed;
        logic exec_pressed;
        logic take_event;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [31:0] exec_hold_ms;
        logic        id_level;
        logic        exec_level;
    } t_out;

endpackage

`default_nettype wire

FILE: src/two_button_event_detector_top.sv
// ----------------------------------------------------------------------------
// two_button_event_detector_top
// debounce and press-event detection for an ID and an EXEC button
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in): one item per sample tick,
//   carrying the raw ID and EXEC levels and a take flag that clears the
//   pending event once it has been reported
//   output channel (o_out_valid / i_out_ready / o_out): exactly one item per
//   input item: pending event, last EXEC hold time and debounced levels
//   configuration: i_cfg_we with i_cfg_idx / i_cfg_wdata writes debounce_ms,
//   long_press_ms or tick_ms in one cycle; write only while idle
// latency and throughput
//   an item sits one cycle in the input register and is then evaluated in a
//   single pass into the result register: two cycles from accept to result,
//   one item per cycle sustained; the path is the clock add, the debounce
//   compare and the hold-time compares, all in one cycle
// reset
//   synchronous, active low: clock, debounce state, timers and the pending
//   event clear to zero, registers take their default values
// stalls
//   a held result keeps the input register full; o_in_ready drops only when
//   both stages are occupied and the receiver is not taking
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_event_detector_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tbed_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tbed_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire tbed_pkg::t_in                      i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output tbed_pkg::t_out                          o_out
);
    import tbed_pkg::*;

    // configuration registers
    logic [15:0] r_debounce_ms;
    logic [15:0] r_long_press_ms;
    logic [9:0]  r_tick_ms;

    // pipeline control
    logic  r_in_valid;
    t_in   r_in;
    logic  r_out_valid;
    t_out  r_out;
    logic  advance;

    // detector state
    logic [31:0] r_clock_ms,       n_clock_ms;
    logic        r_id_stable,      n_id_stable;
    logic        r_exec_stable,    n_exec_stable;
    logic [31:0] r_id_change,      n_id_change;
    logic [31:0] r_exec_change,    n_exec_change;
    logic [31:0] r_id_start,       n_id_start;
    logic        r_id_armed,       n_id_armed;
    logic [31:0] r_exec_start,     n_exec_start;
    logic        r_exec_armed,     n_exec_armed;
    logic [31:0] r_both_start,     n_both_start;
    logic        r_both_armed,     n_both_armed;
    logic        r_lockout,        n_lockout;
    logic [31:0] r_exec_hold,      n_exec_hold;
    logic [2:0]  r_pending,        n_pending;
    logic [2:0]  event_now;

    // result stage frees when empty or being taken; input stage moves on then
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_PRESS_RST;
            r_tick_ms       <= TICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:   r_debounce_ms   <= i_cfg_wdata;
                CFG_LONG_PRESS: r_long_press_ms <= i_cfg_wdata;
                CFG_TICK:       r_tick_ms       <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // single evaluation pass of one tick
    always_comb begin
        logic [31:0] now;
        logic        both;
        logic        done;
        n_clock_ms    = r_clock_ms;
        n_id_stable   = r_id_stable;
        n_exec_stable = r_exec_stable;
        n_id_change   = r_id_change;
        n_exec_change = r_exec_change;
        n_id_start    = r_id_start;
        n_id_armed    = r_id_armed;
        n_exec_start  = r_exec_start;
        n_exec_armed  = r_exec_armed;
        n_both_start  = r_both_start;
        n_both_armed  = r_both_armed;
        n_lockout     = r_lockout;
        n_exec_hold   = r_exec_hold;
        event_now     = r_pending;
        done          = 1'b0;

        now = r_clock_ms + {22'd0, r_tick_ms};
        n_clock_ms = now;

        // time-lockout debounce per button
        if ((r_in.id_pressed != r_id_stable)
            && ((now - r_id_change) > {16'd0, r_debounce_ms})) begin
            n_id_stable = r_in.id_pressed;
            n_id_change = now;
        end
        if ((r_in.exec_pressed != r_exec_stable)
            && ((now - r_exec_change) > {16'd0, r_debounce_ms})) begin
            n_exec_stable = r_in.exec_pressed;
            n_exec_change = now;
        end

        both = n_id_stable && n_exec_stable;

        if (r_lockout) begin
            // wait for both buttons released
            if (!n_id_stable && !n_exec_stable) begin
                n_lockout = 1'b0;
            end
            done = 1'b1;
        end

        if (!done) begin
            if (both) begin
                if (!r_both_armed) begin
                    n_both_start = now;
                    n_both_armed = 1'b1;
                end
                n_id_armed   = 1'b0;
                n_exec_armed = 1'b0;
            end
            if (n_both_armed) begin
                if (!both) begin
                    n_both_armed = 1'b0;
                end else if ((now - n_both_start) >= {16'd0, r_long_press_ms}) begin
                    event_now    = EV_BOTH_LONG;
                    n_both_armed = 1'b0;
                    n_lockout    = 1'b1;
                    done         = 1'b1;
                end
            end
        end

        if (!done) begin
            if (n_id_stable && !n_exec_stable && !n_id_armed) begin
                n_id_start = now;
                n_id_armed = 1'b1;
            end else if (!n_id_stable && n_id_armed) begin
                event_now  = ((now - n_id_start) >= {16'd0, r_long_press_ms})
                             ? EV_ID_LONG_END : EV_ID_SHORT;
                n_id_armed = 1'b0;
            end
            if (n_exec_stable && !n_id_stable && !n_exec_armed) begin
                n_exec_start = now;
                n_exec_armed = 1'b1;
                event_now    = EV_EXEC_PRESS;
            end else if (!n_exec_stable && n_exec_armed) begin
                n_exec_hold  = now - n_exec_start;
                event_now    = EV_EXEC_RELEASE;
                n_exec_armed = 1'b0;
            end
        end

        // take clears after reporting
        n_pending = r_in.take_event ? EV_NONE : event_now;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // result register and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_clock_ms    <= '0;
            r_id_stable   <= 1'b0;
            r_exec_stable <= 1'b0;
            r_id_change   <= '0;
            r_exec_change <= '0;
            r_id_start    <= '0;
            r_id_armed    <= 1'b0;
            r_exec_start  <= '0;
            r_exec_armed  <= 1'b0;
            r_both_start  <= '0;
            r_both_armed  <= 1'b0;
            r_lockout     <= 1'b0;
            r_exec_hold   <= '0;
            r_pending     <= EV_NONE;
        end else begin
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_clock_ms    <= n_clock_ms;
                r_id_stable   <= n_id_stable;
                r_exec_stable <= n_exec_stable;
                r_id_change   <= n_id_change;
                r_exec_change <= n_exec_change;
                r_id_start    <= n_id_start;
                r_id_armed    <= n_id_armed;
                r_exec_start  <= n_exec_start;
                r_exec_armed  <= n_exec_armed;
                r_both_start  <= n_both_start;
                r_both_armed  <= n_both_armed;
                r_lockout     <= n_lockout;
                r_exec_hold   <= n_exec_hold;
                r_pending     <= n_pending;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.event_code   <= event_now;
            r_out.exec_hold_ms <= n_exec_hold;
            r_out.id_level     <= n_id_stable;
            r_out.exec_level   <= n_exec_stable;
        end
    end

endmodule

`default_nettype wire
